// ===== rtl/rbd_pkg.sv =====
`timescale 1ns / 1ps
package rbd_pkg;

    // operation codes carried on the input tuser
    localparam logic [2:0] KIND_INS_REAR   = 3'd0;
    localparam logic [2:0] KIND_RM_FRONT   = 3'd1;
    localparam logic [2:0] KIND_INS_FRONT  = 3'd2;
    localparam logic [2:0] KIND_RM_REAR    = 3'd3;
    localparam logic [2:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [2:0] KIND_PEEK_REAR  = 3'd5;
    localparam logic [2:0] KIND_SEARCH     = 3'd6;

    // result status codes carried on the output tuser
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // field widths
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 4;
    localparam int OUT_W    = 40;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load_read;
        logic srch_step;
        logic srch_hit;
        logic srch_miss;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic out_busy;
        logic match;
        logic walk_done;
    } dp_stat_t;

endpackage

// ===== rtl/rbd_ram.sv =====
`timescale 1ns / 1ps
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/rbd_ctrl.sv =====
`timescale 1ns / 1ps
module rbd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2:0]        kind,
    input  rbd_pkg::dp_stat_t stat,
    output logic              in_ready,
    output rbd_pkg::dp_cmd_t  cmd
);

    import rbd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SRCH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // take a beat only when idle and the result slot frees up
    assign in_ready = (state_reg == S_IDLE) && !stat.out_busy;
    assign accept   = in_valid && in_ready;

    // next state and datapath commands
    always_comb
    begin
        state_next         = state_reg;
        cmd.accept         = accept;
        cmd.load_read      = 1'b0;
        cmd.srch_step      = 1'b0;
        cmd.srch_hit       = 1'b0;
        cmd.srch_miss      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !stat.empty)
                begin
                    case (kind) inside
                        KIND_RM_FRONT, KIND_RM_REAR, KIND_PEEK_FRONT, KIND_PEEK_REAR:
                            state_next = S_READ;
                        KIND_SEARCH:
                            state_next = S_SRCH;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_READ:
            begin
                cmd.load_read = 1'b1;
                state_next    = S_IDLE;
            end
            S_SRCH:
            begin
                cmd.srch_step = 1'b1;
                if (stat.match)
                begin
                    cmd.srch_hit = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.walk_done)
                begin
                    cmd.srch_miss = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/rbd_dp.sv =====
`timescale 1ns / 1ps
module rbd_dp #(
    parameter int DEPTH = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rbd_pkg::dp_cmd_t        cmd,
    input  logic [2:0]              kind,
    input  logic [31:0]             value,
    input  logic                    out_ready,
    output rbd_pkg::dp_stat_t       stat,
    output logic                    out_valid,
    output logic [1:0]              out_status,
    output logic [39:0]             out_data
);

    import rbd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      issued_reg, issued_next;
    logic [VALUE_W-1:0] key_reg, key_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [VALUE_W-1:0]  out_val_reg, out_val_next;
    logic [OCC_W-1:0]    out_occ_reg, out_occ_next;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;

    logic full;
    logic empty;
    logic load_out;
    logic [STATUS_W-1:0] ld_status;
    logic [VALUE_W-1:0]  ld_val;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
        ring_next = (i == LAST_IDX) ? '0 : i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
        ring_prev = (i == '0) ? LAST_IDX : i - AW'(1);
    endfunction

    assign full  = (cnt_reg == FULL_CNT);
    assign empty = (cnt_reg == '0);

    assign stat.empty     = empty;
    assign stat.out_busy  = out_valid_reg && !out_ready;
    assign stat.match     = (rd_data == key_reg);
    assign stat.walk_done = (issued_reg == cnt_reg);

    // pointer, count and walk updates
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        issued_next = issued_reg;
        key_next    = key_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        load_out    = 1'b0;
        ld_status   = STAT_OK;
        ld_val      = '0;
        if (cmd.accept)
        begin
            case (kind) inside
                KIND_INS_REAR:
                begin
                    load_out = 1'b1;
                    if (full)
                    begin
                        ld_status = STAT_OVERFLOW;
                    end
                    else
                    begin
                        tail_next = ring_next(tail_reg);
                        wr_en     = 1'b1;
                        wr_addr   = ring_next(tail_reg);
                        cnt_next  = cnt_reg + CW'(1);
                    end
                end
                KIND_INS_FRONT:
                begin
                    load_out = 1'b1;
                    if (full)
                    begin
                        ld_status = STAT_OVERFLOW;
                    end
                    else
                    begin
                        head_next = ring_prev(head_reg);
                        wr_en     = 1'b1;
                        wr_addr   = ring_prev(head_reg);
                        cnt_next  = cnt_reg + CW'(1);
                    end
                end
                KIND_RM_FRONT, KIND_PEEK_FRONT:
                begin
                    if (empty)
                    begin
                        load_out  = 1'b1;
                        ld_status = STAT_EMPTY;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = head_reg;
                        if (kind == KIND_RM_FRONT)
                        begin
                            head_next = ring_next(head_reg);
                            cnt_next  = cnt_reg - CW'(1);
                        end
                    end
                end
                KIND_RM_REAR, KIND_PEEK_REAR:
                begin
                    if (empty)
                    begin
                        load_out  = 1'b1;
                        ld_status = STAT_EMPTY;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = tail_reg;
                        if (kind == KIND_RM_REAR)
                        begin
                            tail_next = ring_prev(tail_reg);
                            cnt_next  = cnt_reg - CW'(1);
                        end
                    end
                end
                KIND_SEARCH:
                begin
                    if (empty)
                    begin
                        load_out  = 1'b1;
                        ld_status = STAT_EMPTY;
                    end
                    else
                    begin
                        key_next    = value;
                        rd_en       = 1'b1;
                        rd_addr     = head_reg;
                        idx_next    = ring_next(head_reg);
                        issued_next = CW'(1);
                    end
                end
                default:
                begin
                    load_out = 1'b1;
                end
            endcase
        end
        // read result of a remove or peek
        if (cmd.load_read)
        begin
            load_out = 1'b1;
            ld_val   = rd_data;
        end
        // search walk: compare last read, then fetch the next entry
        if (cmd.srch_hit)
        begin
            load_out = 1'b1;
            ld_val   = key_reg;
        end
        else if (cmd.srch_miss)
        begin
            load_out  = 1'b1;
            ld_status = STAT_NOTFOUND;
        end
        else if (cmd.srch_step)
        begin
            rd_en       = 1'b1;
            rd_addr     = idx_reg;
            idx_next    = ring_next(idx_reg);
            issued_next = issued_reg + CW'(1);
        end
    end

    // result slot
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_val_next    = out_val_reg;
        out_occ_next    = out_occ_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ld_status;
            out_val_next    = ld_val;
            out_occ_next    = OCC_W'(cnt_next);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= LAST_IDX;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            issued_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        out_status_reg <= out_status_next;
        out_val_reg    <= out_val_next;
        out_occ_reg    <= out_occ_next;
    end

    rbd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = {{(OUT_W - VALUE_W - OCC_W){1'b0}}, out_occ_reg, out_val_reg};

endmodule

// ===== rtl/ring_buffer_deque_with_search.sv =====
`timescale 1ns / 1ps
// double-ended queue of DEPTH signed 32-bit entries kept in a ring
// input stream: one beat per operation, opcode on s_axis_tuser, operand on s_axis_tdata
//   opcodes: insert rear, remove front, insert front, remove rear,
//   peek front, peek rear, search; code 7 is a no-op
// output stream: exactly one beat per operation with status, data and occupancy
// path from input accept to output valid:
//   insert, no-op, or any empty/overflow case: result loaded straight into the output register
//   remove or peek: registered read of the entry ram, then the output register
//   search: walks from the front, one entry compared per cycle, stops at first match or after the last entry
// throughput: one operation at a time; the next beat is taken once the
//   controller is back in idle and the output slot is empty or being drained
// back-pressure: while m_axis_tready is low the result holds in its output
//   register and s_axis_tready drops until it is taken
// reset: deque empty, front index zero, rear index DEPTH-1; the entry ram
//   is not cleared, since only occupied entries are ever read
module ring_buffer_deque_with_search #(
    parameter int DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] data, [35:32] occupancy, [39:36] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    import rbd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .kind     (s_axis_tuser),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    rbd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .kind       (s_axis_tuser),
        .value      (s_axis_tdata),
        .out_ready  (m_axis_tready),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_data   (m_axis_tdata)
    );

endmodule
